// ----- rtl/mjt_pkg.sv -----
// Shared types and constants for the minimum-jerk trajectory generator.
package mjt_pkg;

   localparam int DATA_W    = 32;
   localparam int MT_W      = 31;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Z  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_TIME = 2'd3;

   localparam logic [MT_W-1:0] MOVE_TIME_RESET = 31'd65536;

   // quintic coefficients in factored form
   localparam int K_SIX     = 6;
   localparam int K_TEN     = 10;
   localparam int K_FIFTEEN = 15;
   localparam int K_THIRTY  = 30;
   localparam int K_SIXTY   = 60;

   typedef struct packed {
      logic        [DATA_W-1:0] elapsed;
      logic signed [DATA_W-1:0] start_x;
      logic signed [DATA_W-1:0] start_y;
      logic signed [DATA_W-1:0] start_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
      logic signed [DATA_W-1:0] acc_x;
      logic signed [DATA_W-1:0] acc_y;
      logic signed [DATA_W-1:0] acc_z;
   } rsp_type;

endpackage

// ----- rtl/mjt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module mjt_div #(
   parameter int NUM_W = 64,
   parameter int QUO_W = 32,
   parameter int TAG_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [NUM_W-1:0]        num,
   input  logic [mjt_pkg::MT_W-1:0] den,
   input  logic [TAG_W-1:0]        tag_in,
   output logic                    out_valid,
   output logic [QUO_W-1:0]        quo,
   output logic                    ovf,
   output logic [TAG_W-1:0]        tag_out
);
   import mjt_pkg::*;

   localparam int DEN_W = MT_W;
   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic             valid_ff [0:QUO_W];
   logic             ovf_ff   [0:QUO_W];
   logic [TAG_W-1:0] tag_ff   [0:QUO_W];
   logic [DEN_W-1:0] rem_ff   [0:QUO_W-1];
   logic [QUO_W-1:0] low_ff   [0:QUO_W-1];
   logic [QUO_W-1:0] quo_ff   [1:QUO_W];

   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;
   logic             big;

   // quotient would need more than QUO_W bits when the top part reaches den
   assign hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
   assign den_ext = CMP_W'(den);
   assign big     = hi_ext >= den_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= big;
         tag_ff[0] <= tag_in;
         rem_ff[0] <= big ? '0 : hi_ext[DEN_W-1:0];
         low_ff[0] <= num[QUO_W-1:0];
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      logic [DEN_W:0] trial;
      logic           ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
      assign ge    = trial >= {1'b0, den};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ovf_ff[k] <= ovf_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end

      if (k == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[k] <= QUO_W'(ge);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[k] <= {quo_ff[k-1][QUO_W-2:0], ge};
            end
         end
      end

      if (k < QUO_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
               low_ff[k] <= low_ff[k-1] << 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign quo       = quo_ff[QUO_W];
   assign ovf       = ovf_ff[QUO_W];
   assign tag_out   = tag_ff[QUO_W];

endmodule

// ----- rtl/mjt_axis.sv -----
// One axis: scales the profile by the travel and divides by the move time.
module mjt_axis #(
   parameter int FRAC_BITS = 16,
   parameter int PW        = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [31:0]       st,
   input  logic signed [32:0]       d,
   input  logic signed [PW-1:0]     s,
   input  logic signed [PW-1:0]     ds,
   input  logic signed [PW-1:0]     dds,
   input  logic [mjt_pkg::MT_W-1:0] den,
   output logic                     out_valid,
   output logic signed [31:0]       pos,
   output logic signed [31:0]       vel,
   output logic signed [31:0]       acc
);
   import mjt_pkg::*;

   localparam int PM_W  = 32 + PW;
   localparam int SV_W  = PM_W - FRAC_BITS + 1;
   localparam int SUM_W = SV_W + 1;
   localparam int QA_W  = 63 - FRAC_BITS;
   localparam logic [PM_W-1:0] HALF = PM_W'(1) << (FRAC_BITS - 1);
   localparam logic [QA_W-1:0] LIM  = QA_W'(1) << (62 - FRAC_BITS);

   typedef struct packed {
      logic signed [31:0]     st;
      logic signed [SV_W-1:0] sv;
      logic [63:0]            anum;
      logic                   aneg;
      logic                   vneg;
   } vel_tag_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic               aneg;
   } acc_tag_type;

   function automatic logic [PW-1:0] magp(input logic signed [PW-1:0] x);
      return x[PW-1] ? PW'(-x) : PW'(x);
   endfunction

   function automatic logic signed [31:0] qsat(input logic [31:0] q, input logic of,
                                               input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         r = (of || q > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q);
      end else begin
         r = (of || q[31]) ? 32'sh7fff_ffff : $signed(q);
      end
      return r;
   endfunction

   // stage 1: magnitude products
   logic [31:0]        dm;
   logic               p1_valid_ff;
   logic signed [31:0] st_ff;
   logic [PM_W-1:0]    ps_ff, pv_ff, pa_ff;
   logic               sneg_ff, vneg_ff, aneg_ff;

   assign dm = d[32] ? 32'(-d) : 32'(d);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff   <= st;
         ps_ff   <= PM_W'(dm) * PM_W'(magp(s));
         pv_ff   <= PM_W'(dm) * PM_W'(magp(ds));
         pa_ff   <= PM_W'(dm) * PM_W'(magp(dds));
         sneg_ff <= d[32] ^ s[PW-1];
         vneg_ff <= d[32] ^ ds[PW-1];
         aneg_ff <= d[32] ^ dds[PW-1];
      end
   end

   // rounding of the position term and the division numerators
   logic [PM_W-1:0]        ms;
   logic signed [SV_W-1:0] svm;
   logic [63:0]            half_t;
   vel_tag_type            vt_in, vt_out;
   logic [63:0]            vnum;

   assign ms     = (ps_ff + HALF) >> FRAC_BITS;
   assign svm    = SV_W'(ms);
   assign half_t = 64'(den >> 1);
   assign vnum   = 64'(pv_ff) + half_t;

   always_comb begin
      vt_in.st   = st_ff;
      vt_in.sv   = sneg_ff ? -svm : svm;
      vt_in.anum = 64'(pa_ff) + half_t;
      vt_in.aneg = aneg_ff;
      vt_in.vneg = vneg_ff;
   end

   logic        v_valid, v_ovf;
   logic [31:0] v_quo;

   mjt_div #(.NUM_W(64), .QUO_W(32), .TAG_W($bits(vel_tag_type))) u_vel_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p1_valid_ff),
      .num       (vnum),
      .den       (den),
      .tag_in    (vt_in),
      .out_valid (v_valid),
      .quo       (v_quo),
      .ovf       (v_ovf),
      .tag_out   (vt_out)
   );

   logic signed [SUM_W-1:0] psum;
   acc_tag_type             a1_in, a1_out, a2_out;

   assign psum = SUM_W'(vt_out.st) + SUM_W'(vt_out.sv);

   always_comb begin
      // out of range when the bits above the sign do not all match it
      if (psum[SUM_W-1:31] != '0 && psum[SUM_W-1:31] != '1) begin
         a1_in.pos = psum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         a1_in.pos = psum[31:0];
      end
      a1_in.vel  = qsat(v_quo, v_ovf, vt_out.vneg);
      a1_in.aneg = vt_out.aneg;
   end

   logic            a1_valid, a1_ovf;
   logic [QA_W-1:0] a1_quo, xm;
   logic [63:0]     a2_num;

   mjt_div #(.NUM_W(64), .QUO_W(QA_W), .TAG_W($bits(acc_tag_type))) u_acc_div1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_valid),
      .num       (vt_out.anum),
      .den       (den),
      .tag_in    (a1_in),
      .out_valid (a1_valid),
      .quo       (a1_quo),
      .ovf       (a1_ovf),
      .tag_out   (a1_out)
   );

   // clamp the intermediate before the second division
   assign xm     = (a1_ovf || a1_quo > LIM) ? LIM : a1_quo;
   assign a2_num = (64'(xm) << FRAC_BITS) + half_t;

   logic        a2_ovf;
   logic [31:0] a2_quo;

   mjt_div #(.NUM_W(64), .QUO_W(32), .TAG_W($bits(acc_tag_type))) u_acc_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a1_valid),
      .num       (a2_num),
      .den       (den),
      .tag_in    (a1_out),
      .out_valid (out_valid),
      .quo       (a2_quo),
      .ovf       (a2_ovf),
      .tag_out   (a2_out)
   );

   assign pos = a2_out.pos;
   assign vel = a2_out.vel;
   assign acc = qsat(a2_quo, a2_ovf, a2_out.aneg);

endmodule

// ----- rtl/min_jerk_trajectory_generator.sv -----
// Minimum-jerk point-to-point trajectory generator, three axes, signed fixed point with
// FRAC_BITS fraction bits. Each request carries an elapsed time and a start point; the
// target point and move time T are written through the csr port, by the user only while no
// request is in flight (the block does not enforce this). The block forms tau = min(t/T, 1)
// and returns position, velocity and acceleration of the quintic profile, every value
// saturated to 32 bits. It is fully pipelined: one request per cycle while the output is
// not stalled. A request passes tau division, three polynomial stages, one product stage,
// bit-per-stage division by T and one output register. A stalled result freezes the
// pipeline only when the last stage also holds a result; bubbles drain.
module min_jerk_trajectory_generator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mjt_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mjt_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [mjt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mjt_pkg::DATA_W-1:0]    csr_wdata
);
   import mjt_pkg::*;

   localparam int PW = FRAC_BITS + 6;
   localparam logic signed [PW-1:0] ONE_Q     = PW'(1) << FRAC_BITS;
   localparam logic signed [PW-1:0] SIX_C     = PW'(K_SIX);
   localparam logic signed [PW-1:0] THIRTY_C  = PW'(K_THIRTY);
   localparam logic signed [PW-1:0] SIXTY_C   = PW'(K_SIXTY);
   localparam logic signed [PW-1:0] TEN_Q     = PW'(K_TEN << FRAC_BITS);
   localparam logic signed [PW-1:0] FIFTEEN_Q = PW'(K_FIFTEEN << FRAC_BITS);
   localparam logic [2*PW-1:0]      HALF      = (2*PW)'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [2:0][31:0] st;
      logic [2:0][32:0] d;
   } axis_tag_type;

   // fixed-point product, magnitude rounded half away from zero
   function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
      logic [PW-1:0]          ma, mb;
      logic [2*PW-1:0]        m;
      logic signed [PW-1:0]   r;
      ma = a[PW-1] ? PW'(-a) : PW'(a);
      mb = b[PW-1] ? PW'(-b) : PW'(b);
      m  = ((2*PW)'(ma) * (2*PW)'(mb) + HALF) >> FRAC_BITS;
      r  = PW'(m);
      return (a[PW-1] ^ b[PW-1]) ? -r : r;
   endfunction

   // configuration registers
   logic signed [31:0]   tgt_ff [3];
   logic [MT_W-1:0]      move_time_ff;
   logic [MT_W-1:0]      den;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff[0]    <= '0;
         tgt_ff[1]    <= '0;
         tgt_ff[2]    <= '0;
         move_time_ff <= MOVE_TIME_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_X:  tgt_ff[0]    <= csr_wdata;
            CSR_TARGET_Y:  tgt_ff[1]    <= csr_wdata;
            CSR_TARGET_Z:  tgt_ff[2]    <= csr_wdata;
            CSR_MOVE_TIME: move_time_ff <= csr_wdata[MT_W-1:0];
         endcase
      end
   end

   // zero move time acts as one LSB
   assign den = (move_time_ff == '0) ? MT_W'(1) : move_time_ff;

   // global advance: hold only when the last stage has a result that cannot leave
   logic       adv;
   logic [2:0] axis_valid;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   assign adv       = rsp_ready || !rsp_valid_ff || !axis_valid[0];
   assign req_ready = adv;

   // tau division
   axis_tag_type            tag_in, tau_tag;
   logic                    tau_valid, tau_ovf;
   logic [FRAC_BITS-1:0]    tau_quo;

   always_comb begin
      tag_in.st[0] = req_data.start_x;
      tag_in.st[1] = req_data.start_y;
      tag_in.st[2] = req_data.start_z;
      tag_in.d[0]  = 33'(tgt_ff[0]) - 33'(req_data.start_x);
      tag_in.d[1]  = 33'(tgt_ff[1]) - 33'(req_data.start_y);
      tag_in.d[2]  = 33'(tgt_ff[2]) - 33'(req_data.start_z);
   end

   mjt_div #(.NUM_W(32 + FRAC_BITS), .QUO_W(FRAC_BITS), .TAG_W($bits(axis_tag_type)))
   u_tau_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .num       ({req_data.elapsed, {FRAC_BITS{1'b0}}}),
      .den       (den),
      .tag_in    (tag_in),
      .out_valid (tau_valid),
      .quo       (tau_quo),
      .ovf       (tau_ovf),
      .tag_out   (tau_tag)
   );

   // elapsed >= T shows up as quotient overflow: tau saturates at one
   logic signed [PW-1:0] tau;
   assign tau = tau_ovf ? ONE_Q : PW'(tau_quo);

   // polynomial stage 1
   logic                 p1_valid_ff;
   axis_tag_type         p1_tag_ff;
   logic signed [PW-1:0] t1_ff, v1_ff, tt1_ff, p61_ff, w1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= tau_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_tag_ff <= tau_tag;
         t1_ff     <= tau;
         v1_ff     <= mulq(tau, ONE_Q - tau);
         tt1_ff    <= mulq(tau, tau);
         p61_ff    <= tau * SIX_C - FIFTEEN_Q;
         w1_ff     <= ONE_Q - tau - tau;
      end
   end

   // polynomial stage 2
   logic                 p2_valid_ff;
   axis_tag_type         p2_tag_ff;
   logic signed [PW-1:0] t3_2_ff, p2_ff, vv2_ff, vw2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_tag_ff <= p1_tag_ff;
         t3_2_ff   <= mulq(tt1_ff, t1_ff);
         p2_ff     <= mulq(p61_ff, t1_ff) + TEN_Q;
         vv2_ff    <= mulq(v1_ff, v1_ff);
         vw2_ff    <= mulq(v1_ff, w1_ff);
      end
   end

   // polynomial stage 3: s, s' and s''
   logic                 p3_valid_ff;
   axis_tag_type         p3_tag_ff;
   logic signed [PW-1:0] s3_ff, ds3_ff, dds3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_tag_ff <= p2_tag_ff;
         s3_ff     <= mulq(p2_ff, t3_2_ff);
         ds3_ff    <= vv2_ff * THIRTY_C;
         dds3_ff   <= vw2_ff * SIXTY_C;
      end
   end

   logic [2:0][31:0] pos_w, vel_w, acc_w;

   for (genvar k = 0; k < 3; k++) begin : g_axis
      mjt_axis #(.FRAC_BITS(FRAC_BITS), .PW(PW)) u_axis (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (p3_valid_ff),
         .st        ($signed(p3_tag_ff.st[k])),
         .d         ($signed(p3_tag_ff.d[k])),
         .s         (s3_ff),
         .ds        (ds3_ff),
         .dds       (dds3_ff),
         .den       (den),
         .out_valid (axis_valid[k]),
         .pos       (pos_w[k]),
         .vel       (vel_w[k]),
         .acc       (acc_w[k])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready || !rsp_valid_ff) begin
         rsp_valid_ff <= axis_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !rsp_valid_ff) begin
         rsp_data_ff.pos_x <= pos_w[0];
         rsp_data_ff.pos_y <= pos_w[1];
         rsp_data_ff.pos_z <= pos_w[2];
         rsp_data_ff.vel_x <= vel_w[0];
         rsp_data_ff.vel_y <= vel_w[1];
         rsp_data_ff.vel_z <= vel_w[2];
         rsp_data_ff.acc_x <= acc_w[0];
         rsp_data_ff.acc_y <= acc_w[1];
         rsp_data_ff.acc_z <= acc_w[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the three axis pipelines run in lockstep
   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      axis_valid[0] == axis_valid[1] && axis_valid[0] == axis_valid[2])
      else $error("axis pipelines out of step");

   // a finished request blocked at the output must stop new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && axis_valid[0]) |-> !req_ready)
      else $error("request taken while pipeline is full and stalled");

   // a result that was not taken is still offered next cycle
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

// ----- verif/min_jerk_trajectory_generator_tb.sv -----
// Self-checking testbench for the minimum-jerk trajectory generator.
module min_jerk_trajectory_generator_tb;
   import mjt_pkg::*;

   localparam int           LATENCY    = 136;
   localparam int           IDLE_LIMIT = 6000;
   localparam int           LONG_HOLD  = 400;
   localparam longint       ONE_Q      = 64'sd65536;
   localparam longint unsigned ACC_CLAMP = 64'd1 << 46;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_X;
   logic [DATA_W-1:0]    csr_wdata = '0;

   min_jerk_trajectory_generator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_motion[$];
   longint          target_q[3];
   longint unsigned move_time_q;
   int  mismatches = 0;
   int  requests_sent = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;
   int  long_hold_asks = 0;
   int  long_hold_seen = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;

   function automatic longint unsigned mag(longint a);
      return a < 0 ? longint'(-a) : a;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint unsigned m;
      m = mag(a) * mag(b);
      m = (m + 64'd32768) >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint div_round(longint num, longint unsigned den);
      longint unsigned m;
      m = (mag(num) + den / 2) / den;
      return num < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // quintic profile per axis; config is stable while requests are in flight
   function automatic rsp_type predict_motion(req_type r);
      longint unsigned period, el, xm;
      longint          tau, v, t3, p, s, ds, dds, st, d, x;
      logic [31:0]     w[9];
      period = (move_time_q == 0) ? 64'd1 : move_time_q;
      el = 64'(r.elapsed);
      tau = (el >= period) ? ONE_Q : longint'((el << 16) / period);
      v = fx_mul(tau, ONE_Q - tau);
      t3 = fx_mul(fx_mul(tau, tau), tau);
      p = fx_mul(6 * tau - 15 * ONE_Q, tau) + 10 * ONE_Q;
      s = fx_mul(p, t3);
      ds = 30 * fx_mul(v, v);
      dds = 60 * fx_mul(v, ONE_Q - 2 * tau);
      for (int k = 0; k < 3; k++) begin
         st = (k == 0) ? longint'(r.start_x) : (k == 1) ? longint'(r.start_y)
                                                     : longint'(r.start_z);
         d = target_q[k] - st;
         w[k] = sat32(st + fx_mul(d, s));
         w[3 + k] = sat32(div_round(d * ds, period));
         x = div_round(d * dds, period);
         xm = mag(x);
         if (xm > ACC_CLAMP) xm = ACC_CLAMP;
         w[6 + k] = sat32(div_round(x < 0 ? -longint'(xm << 16) : longint'(xm << 16),
                                    period));
      end
      return {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]};
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            gap_left <= $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver with random stalls and the occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (long_hold_seen != long_hold_asks) begin
         long_hold_seen <= long_hold_asks;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // expectation on request accept, check on result accept
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && req_ready) begin
         expected_motion.push_back(predict_motion(req_data));
         requests_sent++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_motion.size() == 0) begin
            report("unexpected result", rsp_data.pos_x, 32'h0);
         end else begin
            want = expected_motion.pop_front();
            if (rsp_data.pos_x !== want.pos_x) report("pos_x", rsp_data.pos_x, want.pos_x);
            if (rsp_data.pos_y !== want.pos_y) report("pos_y", rsp_data.pos_y, want.pos_y);
            if (rsp_data.pos_z !== want.pos_z) report("pos_z", rsp_data.pos_z, want.pos_z);
            if (rsp_data.vel_x !== want.vel_x) report("vel_x", rsp_data.vel_x, want.vel_x);
            if (rsp_data.vel_y !== want.vel_y) report("vel_y", rsp_data.vel_y, want.vel_y);
            if (rsp_data.vel_z !== want.vel_z) report("vel_z", rsp_data.vel_z, want.vel_z);
            if (rsp_data.acc_x !== want.acc_x) report("acc_x", rsp_data.acc_x, want.acc_x);
            if (rsp_data.acc_y !== want.acc_y) report("acc_y", rsp_data.acc_y, want.acc_y);
            if (rsp_data.acc_z !== want.acc_z) report("acc_z", rsp_data.acc_z, want.acc_z);
         end
         results_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("min_jerk_trajectory_generator_tb: done, errors");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MOVE_TIME) move_time_q = 64'(val[30:0]);
      else target_q[idx] = longint'(signed'(val));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_motion(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                             logic [30:0] mt);
      write_csr(CSR_TARGET_X, tx);
      write_csr(CSR_TARGET_Y, ty);
      write_csr(CSR_TARGET_Z, tz);
      write_csr(CSR_MOVE_TIME, {1'b0, mt});
   endtask

   task automatic settle();
      while (pending_reqs.size() != 0 || req_valid || expected_motion.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 14) @(posedge clock);
   endtask

   task automatic add_req(logic [31:0] el, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type r;
      r.elapsed = el;
      r.start_x = x;
      r.start_y = y;
      r.start_z = z;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [31:0] rand_start();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      endcase
   endfunction

   task automatic add_random(int count);
      longint unsigned period;
      logic [31:0] el;
      period = (move_time_q == 0) ? 64'd1 : move_time_q;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1: el = $urandom();
            2: el = 32'(period + 64'($urandom_range(0, 4)) - 64'd2);
            default: el = $urandom_range(0, 32'(period + period / 4));
         endcase
         add_req(el, rand_start(), rand_start(), rand_start());
      end
   endtask

   function automatic logic [30:0] rand_period();
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(1, 255));
         1: return 31'($urandom());
         default: return 31'($urandom_range(32'h0000_4000, 32'h0008_0000));
      endcase
   endfunction

   initial begin
      target_q = '{0, 0, 0};
      move_time_q = 64'(MOVE_TIME_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset config: start-of-move, mid, end, past end, quarter
      add_req(32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
      add_req(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000);
      add_req(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
      add_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      add_req(32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      settle();

      // extreme targets, far-apart points drive saturation
      set_motion(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h0001_0000);
      add_req(32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      add_req(32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_req(32'h0000_C000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      add_req(32'h0000_FFFF, 32'h0, 32'h0, 32'h0);
      add_req(32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      settle();

      // zero move time is one LSB; tiny T makes acceleration huge
      set_motion(32'h0001_0000, 32'hFFFF_8000, 32'h7FFF_FFFF, 31'h0);
      add_req(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000);
      add_req(32'h1, 32'h8000_0000, 32'h0, 32'h8000_0000);
      settle();
      write_csr(CSR_MOVE_TIME, 32'h0000_0003);
      add_req(32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      add_req(32'h2, 32'h0000_0001, 32'h0, 32'h8000_0000);
      settle();

      // longest move time
      set_motion(32'h8000_0000, 32'h7FFF_FFFF, 32'h0F0F_0F0F, 31'h7FFF_FFFF);
      add_req(32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      add_req(32'h7FFF_FFFE, 32'h0, 32'h0, 32'hF0F0_F0F0);
      add_req(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
      add_req(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      add_random(80);
      settle();

      // random settings; one phase with a long receiver hold-off
      for (int ph = 0; ph < 6; ph++) begin
         set_motion($urandom_range(0, 1) ? $urandom() : ($urandom_range(0, 32'h00FF_FFFF)
                       - 32'h0080_0000), $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000,
                    $urandom(), rand_period());
         if (ph == 2) long_hold_asks++;
         if (ph == 5) calm = 1'b1;
         add_random(110);
         settle();
      end

      $display("covered %0d requests, %0d results over 11 motion settings,", requests_sent,
               results_seen);
      $display("including zero and maximum move time, extreme targets and a long stall");
      if (mismatches == 0 && expected_motion.size() == 0)
         $display("min_jerk_trajectory_generator_tb: done, clean");
      else
         $display("min_jerk_trajectory_generator_tb: done, errors");
      $finish;
   end

endmodule
